[rtl/bpa_pkg.sv]
`default_nettype none
package bpa_pkg;

    // Pool geometry.
    localparam int NUM_PAGES = 1024;
    localparam int MAX_ORDER = 11;
    localparam int PAGE_W    = 10;
    localparam int ORD_W     = 4;
    localparam int CNT_W     = 11;
    localparam int REQ_W     = 4;
    localparam int STAT_W    = 2;

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_INIT  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        STS_OK        = 2'd0,
        STS_NO_BLOCK  = 2'd1,
        STS_TOO_LARGE = 2'd2,
        STS_BAD_FREE  = 2'd3
    } sts_t;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [4:0] {
        OP_IDLE  = 5'd0,
        OP_START = 5'd1,
        OP_CLR   = 5'd2,
        OP_INEXT = 5'd3,
        OP_RCHK  = 5'd4,
        OP_RTST  = 5'd5,
        OP_U0    = 5'd6,
        OP_U1    = 5'd7,
        OP_U2    = 5'd8,
        OP_P0    = 5'd9,
        OP_P1    = 5'd10,
        OP_P2    = 5'd11,
        OP_P3    = 5'd12,
        OP_ASRCH = 5'd13,
        OP_ATAKE = 5'd14,
        OP_ASPL  = 5'd15,
        OP_FCHK  = 5'd16,
        OP_FORD  = 5'd17,
        OP_DONE  = 5'd18
    } op_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic  req_big;
        logic  cnt_zero;
        logic  cnt_gt1;
        logic  ord_top;
        logic  ord_gt_req;
        logic  buddy_out;
        logic  buddy_match;
        logic  ah_set;
        logic  sweep_last;
        logic  init_more;
        logic  out_free;
        kind_t kind;
    } dp_stat_t;

    typedef struct packed {
        logic [ORD_W-1:0] order;
        logic             free_head;
    } meta_t;

endpackage
`default_nettype wire

[rtl/bpa_ctrl.sv]
`default_nettype none
module bpa_ctrl
    import bpa_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd,
    output logic          s_tready
);

    typedef enum logic [18:0] {
        S_CLR   = 19'h00001,
        S_IDLE  = 19'h00002,
        S_START = 19'h00004,
        S_INEXT = 19'h00008,
        S_RCHK  = 19'h00010,
        S_RTST  = 19'h00020,
        S_U0    = 19'h00040,
        S_U1    = 19'h00080,
        S_U2    = 19'h00100,
        S_P0    = 19'h00200,
        S_P1    = 19'h00400,
        S_P2    = 19'h00800,
        S_P3    = 19'h01000,
        S_ASRCH = 19'h02000,
        S_ATAKE = 19'h04000,
        S_ASPL  = 19'h08000,
        S_FCHK  = 19'h10000,
        S_FORD  = 19'h20000,
        S_DONE  = 19'h40000
    } state_t;

    state_t state_reg, state_next;

    // State register; reset starts the clearing pass.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    // Next state and the operation issued in each state.
    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_IDLE;
        case (state_reg)
            S_CLR: begin
                cmd.op = OP_CLR;
                if (stat.sweep_last) begin
                    state_next = (stat.kind == KIND_INIT) ? S_INEXT : S_IDLE;
                end
            end
            S_IDLE: begin
                cmd.op = OP_IDLE;
                if (s_tvalid) begin
                    state_next = S_START;
                end
            end
            S_START: begin
                cmd.op = OP_START;
                case (stat.kind)
                    KIND_ALLOC: state_next = stat.req_big ? S_DONE : S_ASRCH;
                    KIND_FREE:  state_next = S_FCHK;
                    KIND_INIT:  state_next = S_CLR;
                    default:    state_next = S_DONE;
                endcase
            end
            S_INEXT: begin
                cmd.op     = OP_INEXT;
                state_next = stat.init_more ? S_RCHK : S_DONE;
            end
            S_RCHK: begin
                cmd.op     = OP_RCHK;
                state_next = stat.buddy_out ? S_P0 : S_RTST;
            end
            S_RTST: begin
                cmd.op     = OP_RTST;
                state_next = stat.buddy_match ? S_U0 : S_P0;
            end
            S_U0: begin
                cmd.op     = OP_U0;
                state_next = stat.cnt_gt1 ? S_U1 : S_U2;
            end
            S_U1: begin
                cmd.op     = OP_U1;
                state_next = S_U2;
            end
            S_U2: begin
                cmd.op     = OP_U2;
                state_next = (stat.kind == KIND_ALLOC) ? S_ASPL : S_RCHK;
            end
            S_P0: begin
                cmd.op     = OP_P0;
                state_next = stat.cnt_zero ? S_P3 : S_P1;
            end
            S_P1: begin
                cmd.op     = OP_P1;
                state_next = S_P2;
            end
            S_P2: begin
                cmd.op     = OP_P2;
                state_next = S_P3;
            end
            S_P3: begin
                cmd.op = OP_P3;
                case (stat.kind)
                    KIND_ALLOC: state_next = S_ASPL;
                    KIND_INIT:  state_next = S_INEXT;
                    default:    state_next = S_DONE;
                endcase
            end
            S_ASRCH: begin
                cmd.op = OP_ASRCH;
                if (!stat.cnt_zero) begin
                    state_next = S_ATAKE;
                end else if (stat.ord_top) begin
                    state_next = S_DONE;
                end
            end
            S_ATAKE: begin
                cmd.op     = OP_ATAKE;
                state_next = S_U0;
            end
            S_ASPL: begin
                cmd.op     = OP_ASPL;
                state_next = stat.ord_gt_req ? S_P0 : S_DONE;
            end
            S_FCHK: begin
                cmd.op     = OP_FCHK;
                state_next = stat.ah_set ? S_FORD : S_DONE;
            end
            S_FORD: begin
                cmd.op     = OP_FORD;
                state_next = S_RCHK;
            end
            S_DONE: begin
                cmd.op = OP_DONE;
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLR;
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/bpa_datapath.sv]
`default_nettype none
module bpa_datapath
    import bpa_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire dp_cmd_t           cmd,
    output dp_stat_t               stat,
    input  wire logic              s_tvalid,
    input  wire logic [1:0]        in_kind,
    input  wire logic [REQ_W-1:0]  in_order,
    input  wire logic [PAGE_W-1:0] in_page,
    input  wire logic [CNT_W-1:0]  page_count,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [STAT_W-1:0]      out_status,
    output logic [PAGE_W-1:0]      out_block,
    output logic [CNT_W-1:0]       out_free_pages
);

    // Per-page memories.
    logic [PAGE_W-1:0] next_mem [NUM_PAGES];
    logic [PAGE_W-1:0] prev_mem [NUM_PAGES];
    meta_t             meta_mem [NUM_PAGES];
    logic              ah_mem   [NUM_PAGES];

    // Per-order list heads and counts.
    logic [PAGE_W-1:0] head_reg [MAX_ORDER];
    logic [CNT_W-1:0]  cnt_reg  [MAX_ORDER];

    kind_t             kind_reg;
    logic [REQ_W-1:0]  req_reg;
    logic [PAGE_W-1:0] pg_reg, idx_reg, pidx_reg, uidx_reg, t_reg, sweep_reg;
    logic [CNT_W-1:0]  lim_reg, i_reg, free_reg;
    logic [ORD_W-1:0]  ord_reg;
    logic [STAT_W-1:0] status_reg;
    logic [PAGE_W-1:0] blk_reg;
    logic              m_valid_reg;
    logic [STAT_W-1:0] m_status_reg;
    logic [PAGE_W-1:0] m_block_reg;
    logic [CNT_W-1:0]  m_free_reg;

    // Memory ports.
    logic              next_we, prev_we, meta_we, ah_we;
    logic [PAGE_W-1:0] next_waddr, prev_waddr, meta_waddr, ah_waddr;
    logic [PAGE_W-1:0] next_wdata, prev_wdata;
    meta_t             meta_wdata;
    logic              ah_wdata;
    logic [PAGE_W-1:0] link_raddr, meta_raddr;
    logic [PAGE_W-1:0] next_rd, prev_rd;
    meta_t             meta_rd;
    logic              ah_rd;

    logic [CNT_W-1:0]  cnt_cur, one_sh, b_wide;
    logic [PAGE_W-1:0] head_cur, b_idx;
    logic              out_free;

    assign cnt_cur  = cnt_reg[ord_reg];
    assign head_cur = head_reg[ord_reg];
    assign one_sh   = CNT_W'(1) << ord_reg;
    assign b_wide   = {1'b0, idx_reg} ^ one_sh;
    assign b_idx    = b_wide[PAGE_W-1:0];
    assign out_free = !m_valid_reg || m_tready;

    // Status toward the controller.
    always_comb begin
        stat.req_big     = (req_reg >= REQ_W'(MAX_ORDER));
        stat.cnt_zero    = (cnt_cur == '0);
        stat.cnt_gt1     = (cnt_cur > CNT_W'(1));
        stat.ord_top     = (ord_reg == ORD_W'(MAX_ORDER - 1));
        stat.ord_gt_req  = (ord_reg > req_reg);
        stat.buddy_out   = (ord_reg >= ORD_W'(MAX_ORDER - 1)) || (b_wide >= lim_reg);
        stat.buddy_match = meta_rd.free_head && (meta_rd.order == ord_reg);
        stat.ah_set      = ah_rd;
        stat.sweep_last  = (sweep_reg == PAGE_W'(NUM_PAGES - 1));
        stat.init_more   = (i_reg < lim_reg);
        stat.out_free    = out_free;
        stat.kind        = kind_reg;
    end

    // Memory port selection per operation.
    always_comb begin
        next_we    = 1'b0;
        prev_we    = 1'b0;
        meta_we    = 1'b0;
        ah_we      = 1'b0;
        next_waddr = pidx_reg;
        prev_waddr = pidx_reg;
        meta_waddr = pidx_reg;
        ah_waddr   = pg_reg;
        next_wdata = pidx_reg;
        prev_wdata = pidx_reg;
        meta_wdata = '{order: ord_reg, free_head: 1'b1};
        ah_wdata   = 1'b0;
        link_raddr = uidx_reg;
        meta_raddr = b_idx;
        case (cmd.op)
            OP_CLR: begin
                meta_we    = 1'b1;
                meta_waddr = sweep_reg;
                meta_wdata = '{order: '0, free_head: 1'b0};
                ah_we      = 1'b1;
                ah_waddr   = sweep_reg;
            end
            OP_U1: begin
                next_we    = 1'b1;
                next_waddr = prev_rd;
                next_wdata = next_rd;
                prev_we    = 1'b1;
                prev_waddr = next_rd;
                prev_wdata = prev_rd;
            end
            OP_U2: begin
                meta_we    = 1'b1;
                meta_waddr = uidx_reg;
                meta_wdata = '{order: (kind_reg == KIND_ALLOC) ? ord_reg : '0,
                               free_head: 1'b0};
            end
            OP_P0: begin
                link_raddr = head_cur;
                if (cnt_cur == '0) begin
                    next_we = 1'b1;
                    prev_we = 1'b1;
                end
            end
            OP_P1: begin
                next_we    = 1'b1;
                next_wdata = head_cur;
                prev_we    = 1'b1;
                prev_wdata = prev_rd;
            end
            OP_P2: begin
                next_we    = 1'b1;
                next_waddr = t_reg;
                prev_we    = 1'b1;
                prev_waddr = head_cur;
            end
            OP_P3: begin
                meta_we = 1'b1;
            end
            OP_ASPL: begin
                if (!(ord_reg > req_reg)) begin
                    meta_we    = 1'b1;
                    meta_waddr = idx_reg;
                    meta_wdata = '{order: req_reg, free_head: 1'b0};
                    ah_we      = 1'b1;
                    ah_waddr   = idx_reg;
                    ah_wdata   = 1'b1;
                end
            end
            OP_FCHK: begin
                meta_raddr = pg_reg;
                ah_we      = ah_rd;
            end
            default: begin
            end
        endcase
    end

    // Memories with registered reads.
    always_ff @(posedge aclk) begin
        if (next_we) begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (prev_we) begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        if (meta_we) begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        if (ah_we) begin
            ah_mem[ah_waddr] <= ah_wdata;
        end
        next_rd <= next_mem[link_raddr];
        prev_rd <= prev_mem[link_raddr];
        meta_rd <= meta_mem[meta_raddr];
        ah_rd   <= ah_mem[pg_reg];
    end

    // Work registers and per-order list state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg  <= KIND_ALLOC;
            sweep_reg <= '0;
            free_reg  <= '0;
            for (int k = 0; k < MAX_ORDER; k++) begin
                cnt_reg[k] <= '0;
            end
        end else begin
            case (cmd.op)
                OP_IDLE: begin
                    if (s_tvalid) begin
                        kind_reg <= kind_t'(in_kind);
                        req_reg  <= in_order;
                        pg_reg   <= in_page;
                        lim_reg  <= (page_count > CNT_W'(NUM_PAGES)) ?
                                    CNT_W'(NUM_PAGES) : page_count;
                    end
                end
                OP_START: begin
                    ord_reg    <= req_reg;
                    blk_reg    <= '0;
                    status_reg <= STS_OK;
                    if (kind_reg == KIND_ALLOC && req_reg >= REQ_W'(MAX_ORDER)) begin
                        status_reg <= STS_TOO_LARGE;
                    end
                    if (kind_reg == KIND_INIT) begin
                        sweep_reg <= '0;
                        i_reg     <= '0;
                        free_reg  <= '0;
                        for (int k = 0; k < MAX_ORDER; k++) begin
                            cnt_reg[k] <= '0;
                        end
                    end
                end
                OP_CLR: begin
                    sweep_reg <= sweep_reg + PAGE_W'(1);
                end
                OP_INEXT: begin
                    if (i_reg < lim_reg) begin
                        idx_reg <= i_reg[PAGE_W-1:0];
                        ord_reg <= '0;
                        i_reg   <= i_reg + CNT_W'(1);
                    end
                end
                OP_RCHK: begin
                    pidx_reg <= idx_reg;
                end
                OP_RTST: begin
                    uidx_reg <= b_idx;
                end
                OP_U1: begin
                    if (head_cur == uidx_reg) begin
                        head_reg[ord_reg] <= next_rd;
                    end
                end
                OP_U2: begin
                    cnt_reg[ord_reg] <= cnt_cur - CNT_W'(1);
                    free_reg         <= free_reg - one_sh;
                    if (kind_reg != KIND_ALLOC) begin
                        idx_reg <= idx_reg & ~one_sh[PAGE_W-1:0];
                        ord_reg <= ord_reg + ORD_W'(1);
                    end
                end
                OP_P1: begin
                    t_reg <= prev_rd;
                end
                OP_P3: begin
                    head_reg[ord_reg] <= pidx_reg;
                    cnt_reg[ord_reg]  <= cnt_cur + CNT_W'(1);
                    free_reg          <= free_reg + one_sh;
                end
                OP_ASRCH: begin
                    if (cnt_cur == '0) begin
                        if (ord_reg == ORD_W'(MAX_ORDER - 1)) begin
                            status_reg <= STS_NO_BLOCK;
                        end else begin
                            ord_reg <= ord_reg + ORD_W'(1);
                        end
                    end
                end
                OP_ATAKE: begin
                    idx_reg  <= head_cur;
                    uidx_reg <= head_cur;
                end
                OP_ASPL: begin
                    if (ord_reg > req_reg) begin
                        ord_reg  <= ord_reg - ORD_W'(1);
                        pidx_reg <= idx_reg + (PAGE_W'(1) << (ord_reg - ORD_W'(1)));
                    end else begin
                        blk_reg <= idx_reg;
                    end
                end
                OP_FCHK: begin
                    if (!ah_rd) begin
                        status_reg <= STS_BAD_FREE;
                    end
                end
                OP_FORD: begin
                    ord_reg <= meta_rd.order;
                    idx_reg <= pg_reg;
                end
                default: begin
                end
            endcase
        end
    end

    // Output word register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.op == OP_DONE && out_free) begin
            m_valid_reg  <= 1'b1;
            m_status_reg <= status_reg;
            m_block_reg  <= blk_reg;
            m_free_reg   <= free_reg;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid       = m_valid_reg;
    assign out_status     = m_status_reg;
    assign out_block      = m_block_reg;
    assign out_free_pages = m_free_reg;

endmodule
`default_nettype wire

[rtl/buddy_page_allocator_unit.sv]
`default_nettype none
// Buddy page allocator over a pool of 1024 pages, block orders 0 to 10.
// Input channel s_*: one word per request. s_tuser carries the kind
// (allocate, free, initialize pool); s_tdata carries the requested order and
// the head page to free. Output channel m_*: exactly one word per request with
// status, allocated head page and the free page total after the request.
// cfg_wr_en/cfg_wr_data set the page count of the zone; write it only while
// the block is idle.
// An allocate searches upward past empty orders and then splits; a free merges
// with buddies; each step is bounded by single-port accesses to the link
// memories. Initialize sweeps all 1024 page entries, then releases every page
// of the zone. One request is worked on at a time.
// After reset the block runs a clearing pass over the page memories
// with s_tready low, then the pool is empty until an initialize request.
// A finished word waits in the output register while m_tready is low; the next
// request may be accepted meanwhile but completes only once the register frees.
module buddy_page_allocator_unit
    import bpa_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // [3:0] block_order, [13:4] page_index
    input  wire logic [1:0]  s_tuser,  // [1:0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,  // [1:0] status, [11:2] block_index,
                                       // [22:12] free_pages
    input  wire logic        cfg_wr_en,
    input  wire logic [10:0] cfg_wr_data
);

    logic [CNT_W-1:0]  page_count_reg;
    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic [STAT_W-1:0] out_status;
    logic [PAGE_W-1:0] out_block;
    logic [CNT_W-1:0]  out_free_pages;

    // Page count register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_count_reg <= CNT_W'(NUM_PAGES);
        end else if (cfg_wr_en) begin
            page_count_reg <= cfg_wr_data;
        end
    end

    bpa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .stat     (stat),
        .cmd      (cmd),
        .s_tready (s_tready)
    );

    bpa_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_tvalid       (s_tvalid),
        .in_kind        (s_tuser),
        .in_order       (s_tdata[3:0]),
        .in_page        (s_tdata[13:4]),
        .page_count     (page_count_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .out_status     (out_status),
        .out_block      (out_block),
        .out_free_pages (out_free_pages)
    );

    assign m_tdata = {1'b0, out_free_pages, out_block, out_status};

    // A request is worked on alone: no second word is taken right after one.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a request is in progress");

    // The free total never exceeds the pool.
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[22:12] <= 11'd1024))
        else $error("free page total beyond pool size");

    // A failed request reports head page zero.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] != 2'd0) |-> (m_tdata[11:2] == 10'd0))
        else $error("failed request carries a block index");

endmodule
`default_nettype wire
